FILE: src/assert_macros.svh
// assertion macros used by the core rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/lcsm_pkg.sv
// shared types, constants and the gamma table of the lab similarity core
// no dependencies
`default_nettype none

package lcsm_pkg;

  localparam int unsigned ROOT_STEPS = 17;
  localparam int unsigned CBRT_STG   = ROOT_STEPS + 1;
  localparam int unsigned LAB_STG    = 6 + CBRT_STG + 2;
  localparam int unsigned DIST_STG   = 3 + ROOT_STEPS + 4;
  localparam int unsigned PIPE_STG   = LAB_STG + DIST_STG;

  typedef logic [LAB_STG-1:0]    lab_en_t;
  typedef logic [CBRT_STG-1:0]   cbrt_en_t;
  typedef logic [DIST_STG-1:0]   dist_en_t;
  typedef logic [ROOT_STEPS-1:0] sqrt_en_t;

  typedef logic signed [15:0] lab_val_t;

  typedef struct packed {
    lab_val_t l_val;
    lab_val_t a_val;
    lab_val_t b_val;
  } lab_t;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_t;

  // rgb to xyz matrix, rows x, y, z
  localparam logic [15:0] XYZ_COEF [9] = '{
    16'd27027, 16'd23436, 16'd11829,
    16'd13933, 16'd46871, 16'd4732,
    16'd1265,  16'd7812,  16'd62292
  };

  // white point division by reciprocal
  localparam int unsigned RECIP_SH = 34;
  localparam int unsigned WX_DEN   = 62290;
  localparam int unsigned WX_RND   = 31145;
  localparam int unsigned WZ_DEN   = 71358;
  localparam int unsigned WZ_RND   = 35679;
  localparam logic [18:0] WX_RECIP = 19'((64'd1 << RECIP_SH) / WX_DEN);
  localparam logic [18:0] WZ_RECIP = 19'((64'd1 << RECIP_SH) / WZ_DEN);

  // linear segment of f(t)
  localparam int unsigned F_KNEE    = 580;
  localparam int unsigned F_LIN_MUL = 510329;
  localparam int unsigned F_LIN_OFS = 9039;

  // distance scale, x = ceil(d * SCORE_MUL / SCORE_DEN)
  localparam int unsigned SCORE_MUL   = 6375;
  localparam int unsigned SCORE_DEN   = 2395088;
  localparam int unsigned SCORE_SH    = 32;
  localparam logic [10:0] SCORE_RECIP = 11'((64'd1 << SCORE_SH) / SCORE_DEN);

  localparam int unsigned GAMMA_LIN_DEN = 32946;
  localparam int unsigned GAMMA_T_DEN   = 269025;

  typedef logic [15:0] gamma_lut_t [256];

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic logic [15:0] gamma_entry(int unsigned c);
    longint unsigned cc, t, u, lo, hi, mid, v;
    cc = 64'(c);
    if (cc <= 64'd10) begin
      v = (cc * 64'd655360 + 64'd16473) / GAMMA_LIN_DEN;
      return 16'(v);
    end
    t = ((cc * 64'd1000 + 64'd14025) << 30) / GAMMA_T_DEN;
    u = (t * t) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= u) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    v = (((u * lo) >> 30) + 64'd8192) >> 14;
    if (v > 64'd65535) v = 64'd65535;
    return 16'(v);
  endfunction

  function automatic gamma_lut_t gamma_table();
    gamma_lut_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = gamma_entry(c);
    end
    return tab;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = gamma_table();

endpackage

`default_nettype wire

FILE: src/lcsm_stream_if.sv
// stream interfaces for pixel input and similarity result
// no dependencies
`default_nettype none

interface lcsm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       frame_end;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_end, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_end, output ready);
endinterface

interface lcsm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] similarity;
  logic       frame_end_out;

  modport source (output valid, similarity, frame_end_out, input ready);
  modport sink   (input valid, similarity, frame_end_out, output ready);
endinterface

`default_nettype wire

FILE: src/lcsm_cbrt.sv
// f(t) of the lab conversion: pipelined bit-serial cube root with linear segment
// depends on lcsm_pkg
`default_nettype none

module lcsm_cbrt (
  input  logic                clk,
  input  lcsm_pkg::cbrt_en_t  en,
  input  logic [16:0]         t,
  output logic [16:0]         f
);

  localparam int unsigned NS   = lcsm_pkg::ROOT_STEPS;
  localparam int unsigned NW   = 3 * NS;
  localparam int unsigned RW   = 40;
  localparam int unsigned LAST = NS - 1;

  logic [NW-1:0] n0_r;
  logic          sm0_r;
  logic [14:0]   lin0_r;
  logic [29:0]   lin_p;

  logic [16:0]   y_r   [NS];
  logic          sm_r  [NS];
  logic [14:0]   lin_r [NS];
  logic [33:0]   s_r   [NS-1];
  logic [RW-1:0] rem_r [NS-1];
  logic [NW-1:0] n_r   [NS-1];

  assign lin_p = 30'(t[9:0]) * 30'(lcsm_pkg::F_LIN_MUL) + 30'd32768;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n0_r   <= {2'b00, t, 32'd0};
      sm0_r  <= (t <= 17'(lcsm_pkg::F_KNEE));
      lin0_r <= 15'(lin_p[29:16]) + 15'(lcsm_pkg::F_LIN_OFS);
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [16:0]   y_in;
    logic [33:0]   s_in;
    logic [RW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic          sm_in;
    logic [14:0]   lin_in;
    logic [RW-1:0] rp;
    logic [RW-1:0] bt;
    logic          ge;

    if (j == 0) begin : g_first
      assign y_in   = '0;
      assign s_in   = '0;
      assign r_in   = '0;
      assign n_in   = n0_r;
      assign sm_in  = sm0_r;
      assign lin_in = lin0_r;
    end else begin : g_next
      assign y_in   = y_r[j-1];
      assign s_in   = s_r[j-1];
      assign r_in   = rem_r[j-1];
      assign n_in   = n_r[j-1];
      assign sm_in  = sm_r[j-1];
      assign lin_in = lin_r[j-1];
    end

    assign rp = {r_in[RW-4:0], n_in[NW-1-3*j -: 3]};
    assign bt = RW'({s_in, 3'b000}) + RW'({s_in, 2'b00}) + RW'({y_in, 2'b00})
              + RW'({y_in, 1'b0}) + RW'(1);
    assign ge = (rp >= bt);

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        y_r[j]   <= {y_in[15:0], ge};
        sm_r[j]  <= sm_in;
        lin_r[j] <= lin_in;
      end
    end

    if (j < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j+1]) begin
          s_r[j]   <= ge ? ({s_in[31:0], 2'b00} + 34'({y_in[15:0], 2'b00}) + 34'd1)
                         : {s_in[31:0], 2'b00};
          rem_r[j] <= ge ? (rp - bt) : rp;
          n_r[j]   <= n_in;
        end
      end
    end
  end

  assign f = sm_r[LAST] ? 17'(lin_r[LAST]) : y_r[LAST];

endmodule

`default_nettype wire

FILE: src/lcsm_lab_conv.sv
// srgb to cie lab pipeline: gamma table, xyz matrix, white point, f(t), lab scaling
// depends on lcsm_pkg and lcsm_cbrt
`default_nettype none

module lcsm_lab_conv (
  input  logic               clk,
  input  lcsm_pkg::lab_en_t  en,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output lcsm_pkg::lab_t     lab
);

  localparam int unsigned CB0 = 6;
  localparam int unsigned LS0 = CB0 + lcsm_pkg::CBRT_STG;

  function automatic lcsm_pkg::lab_val_t sat_q8_8(logic signed [27:0] v);
    logic signed [27:0] w;
    logic signed [19:0] q;
    w = v + 28'sd128;
    q = w[27:8];
    if (q > 20'sd32767) return 16'sh7fff;
    if (q < -20'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  logic [15:0] gq_r [3];
  logic [31:0] prod_r [9];
  logic [33:0] sx, sy, sz;
  logic [15:0] x_r, y2_r;
  logic [16:0] z_r;
  logic [32:0] nx, nz;
  logic [32:0] nx3_r, nz3_r;
  logic [51:0] px3_r, pz3_r;
  logic [15:0] y3_r, y4_r;
  logic [32:0] nx4_r, nz4_r;
  logic [16:0] q0x4_r, q0z4_r;
  logic [33:0] qdx4_r, qdz4_r;
  logic [33:0] rx, rz;
  logic [16:0] tx_r, ty_r, tz_r;
  logic [16:0] fx, fy, fz;
  logic signed [27:0] fxs, fys, fzs;
  logic signed [27:0] lv_r, av_r, bv_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      gq_r[0] <= lcsm_pkg::GAMMA_LUT[red];
      gq_r[1] <= lcsm_pkg::GAMMA_LUT[green];
      gq_r[2] <= lcsm_pkg::GAMMA_LUT[blue];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= 32'(gq_r[i % 3]) * 32'(lcsm_pkg::XYZ_COEF[i]);
      end
    end
  end

  assign sx = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]) + 34'd32768;
  assign sy = 34'(prod_r[3]) + 34'(prod_r[4]) + 34'(prod_r[5]) + 34'd32768;
  assign sz = 34'(prod_r[6]) + 34'(prod_r[7]) + 34'(prod_r[8]) + 34'd32768;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_r  <= sx[31:16];
      y2_r <= sy[31:16];
      z_r  <= sz[32:16];
    end
  end

  assign nx = 33'({x_r, 16'h0000}) + 33'(lcsm_pkg::WX_RND);
  assign nz = 33'({z_r, 16'h0000}) + 33'(lcsm_pkg::WZ_RND);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nx3_r <= nx;
      nz3_r <= nz;
      px3_r <= 52'(nx) * 52'(lcsm_pkg::WX_RECIP);
      pz3_r <= 52'(nz) * 52'(lcsm_pkg::WZ_RECIP);
      y3_r  <= y2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nx4_r  <= nx3_r;
      nz4_r  <= nz3_r;
      q0x4_r <= px3_r[50:34];
      q0z4_r <= pz3_r[50:34];
      qdx4_r <= 34'(px3_r[50:34]) * 34'(lcsm_pkg::WX_DEN);
      qdz4_r <= 34'(pz3_r[50:34]) * 34'(lcsm_pkg::WZ_DEN);
      y4_r   <= y3_r;
    end
  end

  assign rx = 34'(nx4_r) - qdx4_r;
  assign rz = 34'(nz4_r) - qdz4_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tx_r <= q0x4_r + 17'(rx >= 34'(lcsm_pkg::WX_DEN));
      tz_r <= q0z4_r + 17'(rz >= 34'(lcsm_pkg::WZ_DEN));
      ty_r <= 17'(y4_r);
    end
  end

  lcsm_cbrt u_cbrt_x (.clk(clk), .en(en[LS0-1:CB0]), .t(tx_r), .f(fx));
  lcsm_cbrt u_cbrt_y (.clk(clk), .en(en[LS0-1:CB0]), .t(ty_r), .f(fy));
  lcsm_cbrt u_cbrt_z (.clk(clk), .en(en[LS0-1:CB0]), .t(tz_r), .f(fz));

  assign fxs = 28'(fx);
  assign fys = 28'(fy);
  assign fzs = 28'(fz);

  always_ff @(posedge clk) begin
    if (en[LS0]) begin
      lv_r <= 28'sd116 * fys - 28'sd1048576;
      av_r <= 28'sd500 * (fxs - fys);
      bv_r <= 28'sd200 * (fys - fzs);
    end
  end

  always_ff @(posedge clk) begin
    if (en[LS0+1]) begin
      lab.l_val <= sat_q8_8(lv_r);
      lab.a_val <= sat_q8_8(av_r);
      lab.b_val <= sat_q8_8(bv_r);
    end
  end

endmodule

`default_nettype wire

FILE: src/lcsm_isqrt.sv
// pipelined bit-serial floor square root, one result bit per stage
// depends on lcsm_pkg
`default_nettype none

module lcsm_isqrt (
  input  logic                clk,
  input  lcsm_pkg::sqrt_en_t  en,
  input  logic [33:0]         n,
  output logic [16:0]         root
);

  localparam int unsigned NS   = lcsm_pkg::ROOT_STEPS;
  localparam int unsigned RW   = 20;
  localparam int unsigned LAST = NS - 1;

  logic [16:0]   y_r   [NS];
  logic [RW-1:0] rem_r [NS-1];
  logic [33:0]   n_r   [NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [16:0]   y_in;
    logic [RW-1:0] r_in;
    logic [33:0]   n_in;
    logic [RW-1:0] rp;
    logic [RW-1:0] bt;
    logic          ge;

    if (j == 0) begin : g_first
      assign y_in = '0;
      assign r_in = '0;
      assign n_in = n;
    end else begin : g_next
      assign y_in = y_r[j-1];
      assign r_in = rem_r[j-1];
      assign n_in = n_r[j-1];
    end

    assign rp = {r_in[RW-3:0], n_in[33-2*j -: 2]};
    assign bt = RW'({y_in, 2'b01});
    assign ge = (rp >= bt);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        y_r[j] <= {y_in[15:0], ge};
      end
    end

    if (j < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= ge ? (rp - bt) : rp;
          n_r[j]   <= n_in;
        end
      end
    end
  end

  assign root = y_r[LAST];

endmodule

`default_nettype wire

FILE: src/lcsm_dist.sv
// lab distance to the reference colour and scaling to the similarity score
// depends on lcsm_pkg and lcsm_isqrt
`default_nettype none

module lcsm_dist (
  input  logic                clk,
  input  lcsm_pkg::dist_en_t  en,
  input  lcsm_pkg::lab_t      pix,
  input  lcsm_pkg::lab_t      refc,
  output logic [7:0]          similarity
);

  localparam int unsigned SQ0 = 3;
  localparam int unsigned SC0 = SQ0 + lcsm_pkg::ROOT_STEPS;

  lcsm_pkg::lab_val_t p_arr [3];
  lcsm_pkg::lab_val_t q_arr [3];
  logic [15:0] ad [3];
  logic [15:0] ad_r [3];
  logic [31:0] sq_r [3];
  logic [33:0] sum_r;
  logic [16:0] dsq;
  logic [29:0] n2_r, n2b_r, n2c_r;
  logic [40:0] pp_r;
  logic [8:0]  q0_r;
  logic [30:0] qk_r;
  logic [30:0] rem;
  logic [9:0]  x;

  assign p_arr = '{pix.l_val, pix.a_val, pix.b_val};
  assign q_arr = '{refc.l_val, refc.a_val, refc.b_val};

  always_comb begin
    logic signed [16:0] df;
    for (int i = 0; i < 3; i++) begin
      df    = {p_arr[i][15], p_arr[i]} - {q_arr[i][15], q_arr[i]};
      ad[i] = df[16] ? 16'(-df) : df[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) ad_r <= ad;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 32'(ad_r[i]) * 32'(ad_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) sum_r <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
  end

  lcsm_isqrt u_isqrt (.clk(clk), .en(en[SC0-1:SQ0]), .n(sum_r), .root(dsq));

  // ceil division folded into the numerator
  always_ff @(posedge clk) begin
    if (en[SC0]) begin
      n2_r <= 30'(dsq) * 30'(lcsm_pkg::SCORE_MUL) + 30'(lcsm_pkg::SCORE_DEN - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SC0+1]) begin
      pp_r  <= 41'(n2_r) * 41'(lcsm_pkg::SCORE_RECIP);
      n2b_r <= n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[SC0+2]) begin
      q0_r  <= pp_r[40:32];
      qk_r  <= 31'(pp_r[40:32]) * 31'(lcsm_pkg::SCORE_DEN);
      n2c_r <= n2b_r;
    end
  end

  assign rem = 31'(n2c_r) - qk_r;
  assign x   = 10'(q0_r) + 10'(rem >= 31'(lcsm_pkg::SCORE_DEN));

  always_ff @(posedge clk) begin
    if (en[SC0+3]) begin
      similarity <= (x >= 10'd255) ? 8'd0 : 8'(10'd255 - x);
    end
  end

endmodule

`default_nettype wire

FILE: src/lab_color_similarity_map_core.sv
// lab color similarity core: one pixel per cycle while the skid stage is empty; the 50
// pixel stages are the gamma/matrix/white-point front, the 18-stage cube root, the lab
// scaling, distance front, 17-stage square root and score divider, all advancing together
// a skid stage after the output register takes one result while the output is stalled
// synchronous active-low reset clears valid bits and the reference color to black;
// a reference write reaches the compare stage through its own unstalled lab conversion
`default_nettype none
`include "assert_macros.svh"

module lab_color_similarity_map_core (
  input  logic        clk,
  input  logic        rst_n,
  lcsm_pix_if.sink    in_pix,
  lcsm_res_if.source  out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned N = lcsm_pkg::PIPE_STG;

  logic [7:0] ref_red_r, ref_green_r, ref_blue_r;
  logic [N-1:0] v_r;
  logic [N-1:0] fe_r;
  logic adv;
  logic out_v_r, skid_v_r;
  logic [7:0] out_sim_r, skid_sim_r;
  logic out_fe_r, skid_fe_r;
  logic [7:0] sim;

  lcsm_pkg::lab_en_t  pix_en, ref_en;
  lcsm_pkg::dist_en_t dist_en;
  lcsm_pkg::lab_t     pix_lab, ref_lab;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_red_r   <= '0;
      ref_green_r <= '0;
      ref_blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcsm_pkg::REG_RED:   ref_red_r   <= cfg_wdata;
        lcsm_pkg::REG_GREEN: ref_green_r <= cfg_wdata;
        lcsm_pkg::REG_BLUE:  ref_blue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv     = !skid_v_r;
  assign pix_en  = {lcsm_pkg::LAB_STG{adv}};
  assign ref_en  = '1;
  assign dist_en = {lcsm_pkg::DIST_STG{adv}};

  lcsm_lab_conv u_pix_lab (
    .clk(clk), .en(pix_en),
    .red(in_pix.pixel_red), .green(in_pix.pixel_green), .blue(in_pix.pixel_blue),
    .lab(pix_lab)
  );

  lcsm_lab_conv u_ref_lab (
    .clk(clk), .en(ref_en),
    .red(ref_red_r), .green(ref_green_r), .blue(ref_blue_r),
    .lab(ref_lab)
  );

  lcsm_dist u_dist (
    .clk(clk), .en(dist_en), .pix(pix_lab), .refc(ref_lab), .similarity(sim)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (adv) v_r <= {v_r[N-2:0], in_pix.valid};
      if (skid_v_r) begin
        if (out_res.ready) skid_v_r <= 1'b0;
      end else if (!out_v_r || out_res.ready) begin
        out_v_r <= v_r[N-1];
      end else if (v_r[N-1]) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) fe_r <= {fe_r[N-2:0], in_pix.frame_end};
    if (skid_v_r) begin
      if (out_res.ready) begin
        out_sim_r <= skid_sim_r;
        out_fe_r  <= skid_fe_r;
      end
    end else if (!out_v_r || out_res.ready) begin
      out_sim_r <= sim;
      out_fe_r  <= fe_r[N-1];
    end else begin
      skid_sim_r <= sim;
      skid_fe_r  <= fe_r[N-1];
    end
  end

  assign in_pix.ready          = adv;
  assign out_res.valid         = out_v_r;
  assign out_res.similarity    = out_sim_r;
  assign out_res.frame_end_out = out_fe_r;

  `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_v_r, out_v_r)
  `ASSERT_NXT(a_accept_loads, clk, rst_n, in_pix.valid && in_pix.ready, v_r[0])
  `ASSERT_NXT(a_stall_holds, clk, rst_n, skid_v_r && !out_res.ready, $stable(v_r))

endmodule

`default_nettype wire
